>>> rtl/kli_pkg.sv
// ----------------------------------------------------------------------------
// kli_pkg
// Shared types and constants for the keyframe linear interpolator.
// ----------------------------------------------------------------------------
package kli_pkg;

  localparam int unsigned MaxKeysDefault = 64;

  localparam logic [1:0] StatusInterp   = 2'd0;
  localparam logic [1:0] StatusHoldFirst = 2'd1;
  localparam logic [1:0] StatusHoldLast = 2'd2;

  localparam logic KindWrite = 1'b0;
  localparam logic KindQuery = 1'b1;

  localparam logic RegKeyCount = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD0,
    ST_CHK0,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SEG_RD,
    ST_SEG_CHK,
    ST_DIV,
    ST_MUL,
    ST_HOLD,
    ST_OUT
  } kli_state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;     // latch query time and clear index
    logic rd_idx;      // read entry at scan index
    logic rd_next;     // read entry at scan index + 1
    logic inc_idx;     // advance scan index
    logic set_last;    // index = count - 1
    logic load_a;      // latch read entry as segment start
    logic div_start;
    logic mul_start;
    logic load_out_a;  // output = segment start values
    logic load_out_res;// output = interpolated values
    logic [1:0] status;
  } kli_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic t_lt_rd;     // query time below time just read
    logic idx_at_last; // scan index + 1 == count - 1
    logic single;      // effective count is 1
    logic degenerate;  // t < t0 or t1 <= t0
    logic div_done;
    logic mul_done;
  } kli_stat_t;

endpackage

>>> rtl/keyframe_linear_interpolator_unit.sv
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator_unit
// Keyframe track store with linear interpolation of xyz values.
//
//   channel  | handshake              | payload
//   in       | in_valid / in_stall    | kind key_index key_time value_x/y/z query_time
//   out      | out_valid / out_stall  | out_x out_y out_z segment status
//   cfg      | APB psel/penable       | key_count at address 0
//
// A write item is stored on acceptance and the unit stays idle. A query for segment i
// reads and checks key 0, then reads and compares each key scanned on the single-port
// key memory, reads the segment keys, waits on the bit-serial divider and then on the
// shared multiplier before it offers its result. Holds finish sooner.
// Reset is synchronous; the key memory is not cleared. Input is stalled while
// a query is in progress or its result waits.
// ----------------------------------------------------------------------------
module keyframe_linear_interpolator_unit #(
  parameter int unsigned MAX_KEYS = kli_pkg::MaxKeysDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [0:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               kind,
  input  logic [5:0]         key_index,
  input  logic [31:0]        key_time,
  input  logic signed [31:0] value_x,
  input  logic signed [31:0] value_y,
  input  logic signed [31:0] value_z,
  input  logic [31:0]        query_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic [5:0]         segment,
  output logic [1:0]         status
);
  import kli_pkg::*;

  logic [6:0] key_count;
  kli_cmd_t   cmd;
  kli_stat_t  stat;
  logic       wr_en;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) key_count <= 7'd1;
    else if (psel && penable && pwrite && paddr == RegKeyCount) key_count <= pwdata[6:0];
  end
  assign prdata = (paddr == RegKeyCount) ? {25'h0, key_count} : 32'h0;

  kli_controller u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_kind(kind),
    .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
    .wr_en(wr_en), .cmd(cmd), .stat(stat)
  );

  kli_datapath #(.MAX_KEYS(MAX_KEYS)) u_dp (
    .clk(clk), .rst(rst), .wr_en(wr_en), .key_index(key_index),
    .key_time(key_time), .value_x(value_x), .value_y(value_y), .value_z(value_z),
    .query_time(query_time), .key_count(key_count), .cmd(cmd), .stat(stat),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .segment(segment), .status(status)
  );
endmodule

>>> rtl/kli_divider.sv
// ----------------------------------------------------------------------------
// kli_divider
// Restoring divider, one quotient bit per cycle: (num << 16) / den.
// ----------------------------------------------------------------------------
module kli_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [47:0] quot
);
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] rem;
  logic [47:0] dividend;
  logic [31:0] dsr;
  logic [33:0] trial;

  assign trial = {rem, dividend[47]} - {2'b00, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= 6'd48;
        rem      <= '0;
        dividend <= {num, 16'h0000};
        dsr      <= den;
      end else if (busy) begin
        if (!trial[33]) begin
          rem  <= trial[32:0];
          quot <= {quot[46:0], 1'b1};
        end else begin
          rem  <= {rem[31:0], dividend[47]};
          quot <= {quot[46:0], 1'b0};
        end
        dividend <= {dividend[46:0], 1'b0};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> rtl/kli_datapath.sv
// ----------------------------------------------------------------------------
// kli_datapath
// Key store, scan compare, divider and one multiplier shared across x, y and z.
// ----------------------------------------------------------------------------
module kli_datapath #(
  parameter int unsigned MAX_KEYS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [5:0]          key_index,
  input  logic [31:0]         key_time,
  input  logic signed [31:0]  value_x,
  input  logic signed [31:0]  value_y,
  input  logic signed [31:0]  value_z,
  input  logic [31:0]         query_time,
  input  logic [6:0]          key_count,
  input  kli_pkg::kli_cmd_t   cmd,
  output kli_pkg::kli_stat_t  stat,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y,
  output logic signed [31:0]  out_z,
  output logic [5:0]          segment,
  output logic [1:0]          status
);
  import kli_pkg::*;

  localparam int unsigned AW = (MAX_KEYS > 64) ? $clog2(MAX_KEYS) : 6;
  localparam int unsigned CW = AW + 1;

  logic [127:0] mem [MAX_KEYS];
  logic [127:0] rd_data;
  logic [AW-1:0] idx;
  logic [31:0]  qt;
  logic [CW-1:0] n_eff;
  logic [CW-1:0] kc_ext;
  logic [31:0]  ta;
  logic signed [31:0] ax, ay, az;
  logic signed [31:0] bx, by, bz;
  logic [15:0]  factor;
  logic [1:0]   mcnt;
  logic         mbusy;
  logic         mul_fin;
  logic signed [32:0] dsel;
  logic signed [31:0] asel;
  logic signed [16:0] fac_s;
  logic signed [82:0] prod;
  logic signed [66:0] q;
  logic signed [31:0] rx, ry, rz;
  logic         div_done;
  logic [47:0]  quot;
  logic [AW:0]  idx_p1;

  assign kc_ext = CW'(key_count);
  always_comb begin
    if (kc_ext == '0) n_eff = CW'(1);
    else if (kc_ext > CW'(MAX_KEYS)) n_eff = CW'(MAX_KEYS);
    else n_eff = kc_ext;
  end

  assign idx_p1 = {1'b0, idx} + {{AW{1'b0}}, 1'b1};

  always_ff @(posedge clk) begin
    if (wr_en && (32'(key_index) < MAX_KEYS))
      mem[AW'(key_index)] <= {key_time, value_x, value_y, value_z};
    if (cmd.rd_idx) rd_data <= mem[idx];
    else if (cmd.rd_next) rd_data <= mem[idx_p1[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.capture) begin
      idx <= '0;
    end else if (cmd.inc_idx) begin
      idx <= idx_p1[AW-1:0];
    end else if (cmd.set_last) begin
      idx <= AW'(n_eff - CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) qt <= query_time;
    if (cmd.load_a) begin
      {ta, ax, ay, az} <= rd_data;
    end
  end

  assign stat.t_lt_rd     = qt < rd_data[127:96];
  assign stat.idx_at_last = (idx_p1 == (n_eff - CW'(1)));
  assign stat.single      = (n_eff == CW'(1));
  assign stat.degenerate  = (qt < ta) || (rd_data[127:96] <= ta);
  assign stat.div_done    = div_done;
  assign stat.mul_done    = mul_fin;

  kli_divider u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start),
    .num(qt - ta), .den(rd_data[127:96] - ta),
    .done(div_done), .quot(quot)
  );

  // t - t0 < t1 - t0, so the factor is below 2^16
  always_ff @(posedge clk) begin
    if (div_done) begin
      factor <= quot[15:0];
      {bx, by, bz} <= rd_data[95:0];
    end
  end

  // one multiplier shared across x, y, z
  always_comb begin
    unique case (mcnt)
      2'd0: begin asel = ax; dsel = 33'(bx) - 33'(ax); end
      2'd1: begin asel = ay; dsel = 33'(by) - 33'(ay); end
      default: begin asel = az; dsel = 33'(bz) - 33'(az); end
    endcase
  end
  assign fac_s = $signed({1'b0, factor});
  assign q = prod[82:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
      mcnt  <= '0;
    end else if (cmd.mul_start) begin
      mbusy <= 1'b1;
      mcnt  <= '0;
    end else if (mbusy) begin
      mcnt <= mcnt + 2'd1;
      if (mcnt == 2'd3) mbusy <= 1'b0;
    end
  end

  // rz lands at the last busy edge, the same edge that raises done
  always_ff @(posedge clk) begin
    if (rst) mul_fin <= 1'b0;
    else mul_fin <= mbusy && (mcnt == 2'd3);
  end

  logic signed [31:0] a_d;
  logic [1:0] mcnt_d;
  always_ff @(posedge clk) begin
    prod   <= 83'(fac_s * dsel);
    a_d    <= asel;
    mcnt_d <= mcnt;
    if (mbusy && mcnt != 2'd0) begin
      // floor shift of product, then add start
      unique case (mcnt_d)
        2'd0: rx <= a_d + q[31:0];
        2'd1: ry <= a_d + q[31:0];
        default: rz <= a_d + q[31:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out_a) begin
      out_x <= rd_data[95:64];
      out_y <= rd_data[63:32];
      out_z <= rd_data[31:0];
      segment <= 6'(idx);
      status <= cmd.status;
    end else if (cmd.load_out_res) begin
      out_x <= rx;
      out_y <= ry;
      out_z <= rz;
      segment <= 6'(idx);
      status <= cmd.status;
    end
  end
endmodule

>>> rtl/kli_controller.sv
// ----------------------------------------------------------------------------
// kli_controller
// Sequencer for writes, key scan, divide, multiply and result hand-off.
// ----------------------------------------------------------------------------
module kli_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_kind,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               wr_en,
  output kli_pkg::kli_cmd_t  cmd,
  input  kli_pkg::kli_stat_t stat
);
  import kli_pkg::*;

  kli_state_t state, state_next;
  logic accept;

  assign in_stall = (state != ST_IDLE);
  assign accept = in_valid && !in_stall;
  assign wr_en = accept && (in_kind == KindWrite);
  assign out_valid = (state == ST_OUT);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept && in_kind == KindQuery) state_next = ST_RD0;
      ST_RD0: state_next = ST_CHK0;
      ST_CHK0: begin
        if (stat.single || stat.t_lt_rd) state_next = ST_HOLD;
        else state_next = ST_SCAN_RD;
      end
      ST_SCAN_RD: state_next = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (stat.t_lt_rd) state_next = ST_SEG_RD;
        else if (stat.idx_at_last) state_next = ST_HOLD;
        else state_next = ST_SCAN_RD;
      end
      ST_SEG_RD: state_next = ST_SEG_CHK;
      ST_SEG_CHK: state_next = stat.degenerate ? ST_HOLD : ST_DIV;
      ST_DIV: if (stat.div_done) state_next = ST_MUL;
      ST_MUL: if (stat.mul_done) state_next = ST_OUT;
      ST_HOLD: state_next = ST_OUT;
      ST_OUT: if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // status of a hold, remembered across the extra read cycle
  logic [1:0] hold_status, hold_status_next;
  always_ff @(posedge clk) begin
    if (rst) hold_status <= StatusHoldFirst;
    else hold_status <= hold_status_next;
  end

  always_comb begin
    cmd = '0;
    hold_status_next = hold_status;
    unique case (state)
      ST_IDLE: begin
        cmd.capture = accept && in_kind == KindQuery;
      end
      ST_RD0: cmd.rd_idx = 1'b1;
      ST_CHK0: begin
        cmd.load_a = 1'b1;
        if (stat.single || stat.t_lt_rd) begin
          cmd.rd_idx = 1'b1;
          hold_status_next = StatusHoldFirst;
        end
      end
      ST_SCAN_RD: cmd.rd_next = 1'b1;
      ST_SCAN_CHK: begin
        if (stat.t_lt_rd) begin
          cmd.rd_idx = 1'b1;
        end else if (stat.idx_at_last) begin
          cmd.set_last = 1'b1;
          hold_status_next = StatusHoldLast;
        end
        else begin
          cmd.inc_idx = 1'b1;
        end
      end
      ST_SEG_RD: cmd.load_a = 1'b1;
      ST_SEG_CHK: begin
        // rd_data holds the end key; a hold re-reads the start key
        if (stat.degenerate) begin
          cmd.rd_idx = 1'b1;
          hold_status_next = StatusInterp;
        end
      end
      ST_DIV: ;
      ST_MUL: begin
        if (stat.mul_done) begin
          cmd.load_out_res = 1'b1;
          cmd.status = StatusInterp;
        end
      end
      ST_HOLD: begin
        cmd.load_out_a = 1'b1;
        cmd.status = hold_status;
      end
      ST_OUT: ;
      default: ;
    endcase
    if (state == ST_SEG_RD) cmd.rd_next = 1'b1;
    if (state == ST_SEG_CHK && !stat.degenerate) cmd.div_start = 1'b1;
    if (state == ST_DIV && stat.div_done) cmd.mul_start = 1'b1;
  end
endmodule

>>> tb/tb_keyframe_linear_interpolator_unit.sv
// ----------------------------------------------------------------------------
// tb_keyframe_linear_interpolator_unit
// Self-checking bench for the keyframe interpolator: keyframe write items and
// query items go in through a queue-fed driver, and a monitor compares every
// sample with the value the bench's own keyframe track computes.
// ----------------------------------------------------------------------------
module tb_keyframe_linear_interpolator_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import kli_pkg::*;

  localparam int NumSlots   = 64;
  localparam int QuietLimit = 8000;
  localparam int DrainWait  = 250;
  localparam int HoldOff    = 400;

  typedef struct {
    logic        kind;
    logic [5:0]  key_index;
    logic [31:0] key_time;
    logic [31:0] value_x;
    logic [31:0] value_y;
    logic [31:0] value_z;
    logic [31:0] query_time;
  } key_item_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [5:0]  seg;
    logic [1:0]  stat;
  } sample_t;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [0:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_stall;
  logic kind = KindWrite;
  logic [5:0] key_index = '0;
  logic [31:0] key_time = '0;
  logic signed [31:0] value_x = '0, value_y = '0, value_z = '0;
  logic [31:0] query_time = '0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [31:0] out_x, out_y, out_z;
  logic [5:0] segment;
  logic [1:0] status;

  keyframe_linear_interpolator_unit dut (.*);

  // bench copy of the track
  logic [31:0] trk_time[NumSlots];
  logic [31:0] trk_x[NumSlots];
  logic [31:0] trk_y[NumSlots];
  logic [31:0] trk_z[NumSlots];
  logic [6:0]  trk_count;

  key_item_t pending_items[$];
  sample_t   expected_samples[$];
  key_item_t cur;
  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int quiet_cycles = 0;
  int holdoff_req = 0;
  int holdoff_seen = 0;
  int holdoff_left = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] lerp(logic [31:0] a, logic [31:0] b,
                                       longint unsigned factor);
    longint s, d, p;
    s = longint'($signed(a));
    d = longint'($signed(b)) - s;
    p = longint'(factor) * d;
    return 32'(s + (p >>> 16));  // floor division by 2^16
  endfunction

  function automatic void sample_track(logic [31:0] t);
    sample_t r;
    int n, seg;
    bit found;
    longint unsigned num, den, factor;
    n = trk_count;
    if (n == 0) n = 1;
    if (n > NumSlots) n = NumSlots;
    found = 0;
    seg = 0;
    if (n == 1 || t < trk_time[0]) begin
      r = '{trk_x[0], trk_y[0], trk_z[0], 6'd0, StatusHoldFirst};
    end else begin
      for (int i = 0; i + 1 < n; i++) begin
        if (!found && t < trk_time[i+1]) begin
          seg = i;
          found = 1;
        end
      end
      if (!found) begin
        seg = n - 1;
        r = '{trk_x[seg], trk_y[seg], trk_z[seg], 6'(seg), StatusHoldLast};
      end else if (t < trk_time[seg] || trk_time[seg+1] <= trk_time[seg]) begin
        r = '{trk_x[seg], trk_y[seg], trk_z[seg], 6'(seg), StatusInterp};
      end else begin
        num = longint'(t - trk_time[seg]) << 16;
        den = longint'(trk_time[seg+1] - trk_time[seg]);
        factor = num / den;
        r.x = lerp(trk_x[seg], trk_x[seg+1], factor);
        r.y = lerp(trk_y[seg], trk_y[seg+1], factor);
        r.z = lerp(trk_z[seg], trk_z[seg+1], factor);
        r.seg = 6'(seg);
        r.stat = StatusInterp;
      end
    end
    expected_samples.push_back(r);
  endfunction

  function automatic void apply_item(key_item_t it);
    if (it.kind == KindWrite) begin
      trk_time[it.key_index] = it.key_time;
      trk_x[it.key_index] = it.value_x;
      trk_y[it.key_index] = it.value_y;
      trk_z[it.key_index] = it.value_z;
    end else begin
      sample_track(it.query_time);
    end
  endfunction

  function automatic void push_write(int idx, logic [31:0] t, logic [31:0] x,
                                     logic [31:0] y, logic [31:0] z);
    pending_items.push_back('{KindWrite, 6'(idx), t, x, y, z, $urandom});
  endfunction

  function automatic void push_query(logic [31:0] t);
    pending_items.push_back('{KindQuery, 6'($urandom), $urandom, $urandom,
                              $urandom, $urandom, t});
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else begin
      if (in_valid && !in_stall) apply_item(cur);
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
          cur = pending_items.pop_front();
          kind <= cur.kind;
          key_index <= cur.key_index;
          key_time <= cur.key_time;
          value_x <= cur.value_x;
          value_y <= cur.value_y;
          value_z <= cur.value_z;
          query_time <= cur.query_time;
          in_valid <= 1;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    sample_t e;
    if (rst) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          errors++;
          $display("%0t: unexpected sample x=%h y=%h z=%h seg=%0d status=%0d",
                   $realtime, out_x, out_y, out_z, segment, status);
        end else begin
          e = expected_samples.pop_front();
          if (out_x !== e.x) begin
            errors++;
            $display("%0t: out_x expected %h actual %h", $realtime, e.x, out_x);
          end
          if (out_y !== e.y) begin
            errors++;
            $display("%0t: out_y expected %h actual %h", $realtime, e.y, out_y);
          end
          if (out_z !== e.z) begin
            errors++;
            $display("%0t: out_z expected %h actual %h", $realtime, e.z, out_z);
          end
          if (segment !== e.seg) begin
            errors++;
            $display("%0t: segment expected %0d actual %0d", $realtime, e.seg, segment);
          end
          if (status !== e.stat) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $realtime, e.stat, status);
          end
        end
      end
      if (holdoff_seen != holdoff_req) begin
        holdoff_seen = holdoff_req;
        holdoff_left = HoldOff;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_stall <= 1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_key_count(logic [6:0] v);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= RegKeyCount;
    pwdata <= {$urandom_range(1) ? 25'h1ffffff : 25'h0, v};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    trk_count = v;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_samples.size() > 0)
      @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  // random track over slots 0..nslots-1, then queries mostly inside it
  task automatic fill_track(int nslots, int nq);
    logic [31:0] t, lo, hi, q;
    int pick;
    t = $urandom_range(3) == 0 ? 32'h0 : $urandom_range(32'h0100_0000);
    lo = t;
    for (int i = 0; i < nslots; i++) begin
      pick = $urandom_range(9);
      if (i > 0) begin
        if (pick == 0) t = t;                       // zero-length segment
        else if (pick == 1) t = t - $urandom_range(32'h0002_0000); // unordered
        else if (pick < 5) t = t + $urandom_range(32'h0000_ffff);
        else t = t + $urandom_range(32'h0100_0000);
      end
      push_write(i, t, $urandom, $urandom, $urandom);
    end
    hi = t;
    for (int k = 0; k < nq; k++) begin
      pick = $urandom_range(19);
      if (pick == 0) q = $urandom;
      else if (pick == 1) q = lo - $urandom_range(8);
      else if (pick == 2) q = hi + $urandom_range(8);
      else if (pick == 3) q = 32'hffff_ffff;
      else q = (hi > lo) ? lo + $urandom_range(hi - lo) : lo + $urandom_range(3);
      push_query(q);
      // occasional rewrite of a slot inside the track
      if ($urandom_range(15) == 0)
        push_write($urandom_range(nslots - 1), $urandom_range(hi - lo) + lo,
                   $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    int counts[8] = '{64, 2, 0, 127, 33, 64, 5, 1};
    int idles[4] = '{0, 76, 0, 26};
    int stalls[4] = '{0, 0, 76, 26};
    int n;
    repeat (11) @(posedge clk);
    rst <= 0;
    trk_count = 1;

    // single key: every query holds the first key
    push_write(0, 32'h0001_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0);
    push_query(32'h0);
    push_query(32'hffff_ffff);
    push_query(32'h0001_0000);
    drain();
    write_key_count(7'd4);
    push_write(1, 32'h0003_0000, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    push_write(2, 32'h0003_0000, 32'h0, 32'h1, 32'h8000_0000);
    push_write(3, 32'hffff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 32'h7fff_ffff);
    push_query(32'h0000_0005);   // before first key
    push_query(32'h0002_0000);   // middle of first segment
    push_query(32'h0002_ffff);
    push_query(32'h0003_0000);   // skips zero-length segment
    push_query(32'hffff_fffe);
    push_query(32'hffff_ffff);   // at last key
    push_write(2, 32'h0002_0000, 32'h1234_5678, 32'hedcb_a987, 32'h0);  // unordered
    push_query(32'h0002_8000);
    push_query(32'h0003_8000);
    push_write(0, 32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'h1);
    push_query(32'h0);
    push_query(32'h0000_8000);
    drain();

    for (int p = 0; p < 8; p++) begin
      idle_pct = idles[p % 4];
      stall_pct = stalls[p % 4];
      write_key_count(7'(counts[p]));
      n = counts[p] == 0 ? 1 : (counts[p] > NumSlots ? NumSlots : counts[p]);
      fill_track(p == 0 ? NumSlots : (n < 2 ? 2 : n), 130 - (p == 0 ? 40 : n / 2));
      if (p == 1) holdoff_req++;
      drain();
    end

    if (errors == 0 && expected_samples.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
